[rtl/csim_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, types and constants of the cosine similarity engine.
package csim_pkg;

	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W  = 48;
	localparam int OUT_W  = 16;
	localparam int FRAC   = 15;
	localparam int Q_W    = 16;
	localparam int CNT_W  = 4;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [ACC_W-1:0]        uacc_t;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic signed [OUT_W-1:0] SIM_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SIM_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// Highest even power of two that a nonnegative accumulator can reach.
	localparam uacc_t ROOT_BIT_INIT = {2'b01, {(ACC_W-2){1'b0}}};

	// Finished sums of one vector pair, handed from the front to the back.
	typedef struct packed {
		acc_t dot;
		acc_t norm_a;
		acc_t norm_b;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_MUL,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} back_state_t;

endpackage

[rtl/csim_front.sv]
`timescale 1ns / 1ps
// Front end: accepts element pairs and keeps the three saturating running sums.
module csim_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [csim_pkg::ELEM_W-1:0] elem_a,
	input  logic signed [csim_pkg::ELEM_W-1:0] elem_b,
	input  logic                        last,
	output logic                        push,
	output csim_pkg::job_t              push_job,
	input  logic                        queue_full
);

	csim_pkg::acc_t dot_q;
	csim_pkg::acc_t norm_a_q;
	csim_pkg::acc_t norm_b_q;
	csim_pkg::acc_t dot_nxt;
	csim_pkg::acc_t norm_a_nxt;
	csim_pkg::acc_t norm_b_nxt;
	logic signed [csim_pkg::PROD_W-1:0] p_ab;
	logic signed [csim_pkg::PROD_W-1:0] p_aa;
	logic signed [csim_pkg::PROD_W-1:0] p_bb;
	logic accept;

	function automatic csim_pkg::acc_t sat_add(csim_pkg::acc_t acc,
			logic signed [csim_pkg::PROD_W-1:0] p);
		logic signed [csim_pkg::ACC_W:0] s;
		s = {acc[csim_pkg::ACC_W-1], acc}
			+ {{(csim_pkg::ACC_W+1-csim_pkg::PROD_W){p[csim_pkg::PROD_W-1]}}, p};
		if (s[csim_pkg::ACC_W] != s[csim_pkg::ACC_W-1]) begin
			return s[csim_pkg::ACC_W] ? csim_pkg::ACC_MIN : csim_pkg::ACC_MAX;
		end
		return s[csim_pkg::ACC_W-1:0];
	endfunction

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;

	assign p_ab = elem_a * elem_b;
	assign p_aa = elem_a * elem_a;
	assign p_bb = elem_b * elem_b;

	assign dot_nxt    = sat_add(dot_q, p_ab);
	assign norm_a_nxt = sat_add(norm_a_q, p_aa);
	assign norm_b_nxt = sat_add(norm_b_q, p_bb);

	assign push            = accept && last;
	assign push_job.dot    = dot_nxt;
	assign push_job.norm_a = norm_a_nxt;
	assign push_job.norm_b = norm_b_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q    <= '0;
			norm_a_q <= '0;
			norm_b_q <= '0;
		end else if (accept) begin
			if (last) begin
				dot_q    <= '0;
				norm_a_q <= '0;
				norm_b_q <= '0;
			end else begin
				dot_q    <= dot_nxt;
				norm_a_q <= norm_a_nxt;
				norm_b_q <= norm_b_nxt;
			end
		end
	end

	// Squared norms only ever grow from zero, so they can never turn negative.
	a_norm_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!norm_a_q[csim_pkg::ACC_W-1] && !norm_b_q[csim_pkg::ACC_W-1])
		else $error("norm accumulator went negative");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (dot_q == '0) && (norm_a_q == '0) && (norm_b_q == '0))
		else $error("sums not cleared after the last item");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && queue_full))
		else $error("job pushed into a full queue");

endmodule

[rtl/csim_queue.sv]
`timescale 1ns / 1ps
// Two-entry job queue between the accumulating front and the arithmetic back.
module csim_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  csim_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           job_valid,
	output csim_pkg::job_t job
);

	csim_pkg::job_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign job_valid = (count_q != 2'd0);
	assign job       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !job_valid))
		else $error("job popped from an empty queue");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

[rtl/csim_back.sv]
`timescale 1ns / 1ps
// Back end: square roots, root product, restoring division and the result register.
module csim_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	input  csim_pkg::job_t                    job,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [csim_pkg::OUT_W-1:0] similarity,
	output logic                              zero_norm
);

	csim_pkg::back_state_t state_q;
	csim_pkg::back_state_t state_nxt;

	csim_pkg::uacc_t xa_q, xb_q, ra_q, rb_q, bit_q;
	csim_pkg::uacc_t mag_q, den_q, rem_q;
	logic [csim_pkg::Q_W-1:0]   nbits_q;
	logic [csim_pkg::Q_W-1:0]   quo_q;
	logic [csim_pkg::CNT_W-1:0] cnt_q;
	logic neg_q, zero_q, sat_q;
	logic out_valid_q;
	logic signed [csim_pkg::OUT_W-1:0] sim_q;
	logic zero_out_q;

	csim_pkg::uacc_t trial_a, trial_b;
	logic [csim_pkg::ACC_W:0] rem_sh;
	logic [csim_pkg::ACC_W:0] den_x2;
	logic rem_ge;
	logic load_out;
	logic signed [csim_pkg::OUT_W-1:0] sim_nxt;

	assign trial_a = ra_q + bit_q;
	assign trial_b = rb_q + bit_q;
	assign rem_sh  = {rem_q, nbits_q[csim_pkg::Q_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, den_q};
	assign den_x2  = {den_q, 1'b0};

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			csim_pkg::ST_IDLE: begin
				if (job_valid) begin
					state_nxt = (job.norm_a == '0 || job.norm_b == '0)
						? csim_pkg::ST_DONE : csim_pkg::ST_SQRT;
				end
			end
			csim_pkg::ST_SQRT: begin
				if (bit_q[0]) begin
					state_nxt = csim_pkg::ST_MUL;
				end
			end
			csim_pkg::ST_MUL: state_nxt = csim_pkg::ST_CHECK;
			csim_pkg::ST_CHECK: begin
				state_nxt = ({1'b0, mag_q} >= den_x2) ? csim_pkg::ST_DONE : csim_pkg::ST_DIV;
			end
			csim_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_nxt = csim_pkg::ST_DONE;
				end
			end
			csim_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = csim_pkg::ST_IDLE;
				end
			end
			default: state_nxt = csim_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == csim_pkg::ST_IDLE) && job_valid;
		load_out = (state_q == csim_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	end

	// A negative quotient may reach one step further than a positive one.
	always_comb begin
		if (zero_q) begin
			sim_nxt = '0;
		end else if (neg_q) begin
			if (sat_q || quo_q > {1'b1, {(csim_pkg::Q_W-1){1'b0}}}) begin
				sim_nxt = csim_pkg::SIM_MIN;
			end else begin
				sim_nxt = -$signed(quo_q);
			end
		end else begin
			if (sat_q || quo_q[csim_pkg::Q_W-1]) begin
				sim_nxt = csim_pkg::SIM_MAX;
			end else begin
				sim_nxt = $signed(quo_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csim_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			csim_pkg::ST_IDLE: begin
				xa_q   <= job.norm_a;
				xb_q   <= job.norm_b;
				ra_q   <= '0;
				rb_q   <= '0;
				bit_q  <= csim_pkg::ROOT_BIT_INIT;
				neg_q  <= job.dot[csim_pkg::ACC_W-1];
				mag_q  <= job.dot[csim_pkg::ACC_W-1] ? -job.dot : job.dot;
				zero_q <= (job.norm_a == '0) || (job.norm_b == '0);
				sat_q  <= 1'b0;
				quo_q  <= '0;
			end
			csim_pkg::ST_SQRT: begin
				if (xa_q >= trial_a) begin
					xa_q <= xa_q - trial_a;
					ra_q <= (ra_q >> 1) + bit_q;
				end else begin
					ra_q <= ra_q >> 1;
				end
				if (xb_q >= trial_b) begin
					xb_q <= xb_q - trial_b;
					rb_q <= (rb_q >> 1) + bit_q;
				end else begin
					rb_q <= rb_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			csim_pkg::ST_MUL: begin
				den_q <= ra_q[csim_pkg::ACC_W/2-1:0] * rb_q[csim_pkg::ACC_W/2-1:0];
			end
			csim_pkg::ST_CHECK: begin
				// The quotient needs more than Q_W bits exactly when mag reaches twice den.
				sat_q   <= ({1'b0, mag_q} >= den_x2);
				rem_q   <= mag_q >> 1;
				nbits_q <= {mag_q[0], {(csim_pkg::Q_W-1){1'b0}}};
				cnt_q   <= csim_pkg::CNT_W'(csim_pkg::Q_W - 1);
			end
			csim_pkg::ST_DIV: begin
				if (rem_ge) begin
					rem_q <= csim_pkg::ACC_W'(rem_sh - {1'b0, den_q});
				end else begin
					rem_q <= rem_sh[csim_pkg::ACC_W-1:0];
				end
				quo_q   <= {quo_q[csim_pkg::Q_W-2:0], rem_ge};
				nbits_q <= nbits_q << 1;
				cnt_q   <= cnt_q - 1'b1;
			end
			csim_pkg::ST_DONE: begin
				if (load_out) begin
					sim_q      <= sim_nxt;
					zero_out_q <= zero_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign similarity = sim_q;
	assign zero_norm  = zero_out_q;

	a_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == csim_pkg::ST_SQRT) |-> $onehot(bit_q))
		else $error("root trial bit lost its single set bit");

	a_zero_sim: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_norm) |-> (similarity == '0))
		else $error("zero norm result with nonzero similarity");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == csim_pkg::ST_DIV) |-> (rem_q < den_q))
		else $error("division remainder not below divisor");

	a_load_on_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while held");

endmodule

[rtl/cosine_similarity_engine_top.sv]
`timescale 1ns / 1ps
// Cosine similarity engine: element pairs come in at one item per clock unless
// stalled and feed three saturating 48-bit Q18.30 sums; the item marked last hands
// the finished sums through a two-entry queue to the arithmetic back end, which
// produces one Q1.15 result from square roots of both norms in shared steps, the
// root product, a range check and a 16-bit restoring division, then the output
// register; it skips the division when the range check already shows that the
// quotient saturates, and goes straight to the output register when a norm is zero.
// The input stalls only when two finished vector pairs are already queued; the back
// end takes the next vector pair only after the last result is in the output register.
module cosine_similarity_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] elem_a,
	input  logic signed [15:0] elem_b,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] similarity,
	output logic        zero_norm
);

	logic           push;
	logic           queue_full;
	logic           pop;
	logic           job_valid;
	csim_pkg::job_t push_job;
	csim_pkg::job_t job;

	csim_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.elem_a     (elem_a),
		.elem_b     (elem_b),
		.last       (last),
		.push       (push),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	csim_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.job_valid (job_valid),
		.job       (job)
	);

	csim_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.similarity (similarity),
		.zero_norm  (zero_norm)
	);

endmodule
